/* rtl/core/c8alu_pkg.sv */
// Shared types for the 8-bit ALU with decimal arithmetic.
package c8alu_pkg;

  typedef enum logic [3:0] {
    OP_ADC = 4'd0,
    OP_AND = 4'd1,
    OP_ASL = 4'd2,
    OP_BIT = 4'd3,
    OP_CMP = 4'd4,
    OP_CPX = 4'd5,
    OP_CPY = 4'd6,
    OP_DEC = 4'd7,
    OP_EOR = 4'd8,
    OP_INC = 4'd9,
    OP_LD  = 4'd10,
    OP_LSR = 4'd11,
    OP_ORA = 4'd12,
    OP_ROL = 4'd13,
    OP_ROR = 4'd14,
    OP_SBC = 4'd15
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] operand;
    logic [7:0] accumulator;
    logic [7:0] index_x;
    logic [7:0] index_y;
    logic       carry_in;
    logic       overflow_in;
    logic       decimal_in;
  } req_t;

  typedef struct packed {
    logic [7:0] result;
    logic       carry;
    logic       zero;
    logic       negative;
    logic       overflow;
    logic       penalty;
  } res_t;

endpackage

/* rtl/core/cpu8_alu_with_decimal_mode_top.sv */
// Top level of the 8-bit ALU with decimal mode: input register, datapath, result register.
//
// Eight-bit processor ALU with optional BCD arithmetic. Each input beat carries
// an operation code, the operand, A, X, Y and the C, V and D flags; each output
// beat carries the result byte, the new C, Z, N and V flags and a penalty bit
// that marks a decimal-mode ADC or SBC. Flags an operation does not touch are
// passed through from the input beat. Each beat passes through the input
// register, then the result register, and one beat is taken every cycle as
// long as the output side keeps up; a stalled output backs up through the
// two registers, so in_ready falls only once both
// hold a beat. Decimal arithmetic is allowed while cfg_wr_en has last written
// a 1 into decimal_enable (1 after reset); with it at 0, ADC and SBC are
// always binary. Write the register only while no beat is in flight.
module cpu8_alu_with_decimal_mode_top (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_req_type,
  input  logic [7:0] in_operand,
  input  logic [7:0] in_accumulator,
  input  logic [7:0] in_index_x,
  input  logic [7:0] in_index_y,
  input  logic       in_carry_in,
  input  logic       in_overflow_in,
  input  logic       in_decimal_in,
  // output channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_result,
  output logic       out_carry_out,
  output logic       out_zero_out,
  output logic       out_negative_out,
  output logic       out_overflow_out,
  output logic       out_decimal_penalty
);

  logic            dec_en_r;
  logic            s1_valid_r;
  c8alu_pkg::req_t s1_req_r;
  c8alu_pkg::res_t s1_res;
  logic            out_valid_r;
  c8alu_pkg::res_t out_res_r;
  logic            s1_adv;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      dec_en_r <= cfg_wr_data;
    end
  end

  // stage 1 moves on when the result register is empty or being drained
  assign s1_adv   = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r.op          <= c8alu_pkg::op_t'(in_req_type);
      s1_req_r.operand     <= in_operand;
      s1_req_r.accumulator <= in_accumulator;
      s1_req_r.index_x     <= in_index_x;
      s1_req_r.index_y     <= in_index_y;
      s1_req_r.carry_in    <= in_carry_in;
      s1_req_r.overflow_in <= in_overflow_in;
      s1_req_r.decimal_in  <= in_decimal_in;
    end
  end

  c8alu_exec u_exec (
    .req            (s1_req_r),
    .decimal_enable (dec_en_r),
    .res            (s1_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (~out_valid_r | out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= s1_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result          = out_res_r.result;
  assign out_carry_out       = out_res_r.carry;
  assign out_zero_out        = out_res_r.zero;
  assign out_negative_out    = out_res_r.negative;
  assign out_overflow_out    = out_res_r.overflow;
  assign out_decimal_penalty = out_res_r.penalty;

  // a beat leaving stage 1 always lands in the result register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("stage 1 beat lost");

  // both registers full and output stalled: no new beat may enter
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline full");

  // penalty only for decimal ADC/SBC with decimal support enabled
  a_penalty_src: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_res.penalty) |->
      (dec_en_r && s1_req_r.decimal_in &&
       (s1_req_r.op == c8alu_pkg::OP_ADC || s1_req_r.op == c8alu_pkg::OP_SBC)))
    else $error("decimal penalty raised outside decimal add/subtract");

  // decimal path leaves V alone
  a_dec_v_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_res.penalty) |-> (s1_res.overflow == s1_req_r.overflow_in))
    else $error("overflow changed in decimal mode");

endmodule

/* rtl/core/c8alu_exec.sv */
// Combinational ALU datapath: logic, shifts, compares, binary and BCD add/subtract.
module c8alu_exec (
  input  c8alu_pkg::req_t req,
  input  logic            decimal_enable,
  output c8alu_pkg::res_t res
);

  logic [7:0] m_eff;
  logic [8:0] bin_sum;
  logic       bin_v;
  logic [5:0] lo_sum;
  logic [5:0] lo_adj;
  logic       lo_carry;
  logic [9:0] hi_sum;
  logic [9:0] dec_sum;
  logic       use_dec;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic       is_sbc;

  assign is_sbc  = (req.op == c8alu_pkg::OP_SBC);
  // SBC is ADC of the ones' complement
  assign m_eff   = is_sbc ? ~req.operand : req.operand;
  assign bin_sum = {1'b0, req.accumulator} + {1'b0, m_eff} + {8'd0, req.carry_in};
  assign bin_v   = ~(req.accumulator[7] ^ m_eff[7]) & (req.accumulator[7] ^ bin_sum[7]);
  assign use_dec = decimal_enable & req.decimal_in;

  // low digit
  assign lo_sum = {2'b00, req.accumulator[3:0]} + {2'b00, m_eff[3:0]}
                + {5'd0, req.carry_in};

  always_comb begin
    if (is_sbc) begin
      lo_carry = (lo_sum > 6'h0f);
      lo_adj   = lo_carry ? lo_sum : (lo_sum - 6'h06);
    end else begin
      lo_adj   = (lo_sum > 6'h09) ? (lo_sum + 6'h06) : lo_sum;
      lo_carry = (lo_adj > 6'h0f);
    end
  end

  // high digit, 10-bit total
  assign hi_sum = {2'b00, req.accumulator[7:4], 4'h0} + {2'b00, m_eff[7:4], 4'h0}
                + {5'd0, lo_carry, 4'h0} + {6'd0, lo_adj[3:0]};

  always_comb begin
    if (is_sbc) begin
      dec_sum = (hi_sum <= 10'h0ff) ? (hi_sum - 10'h060) : hi_sum;
    end else begin
      dec_sum = (hi_sum > 10'h09f) ? (hi_sum + 10'h060) : hi_sum;
    end
  end

  always_comb begin
    case (req.op)
      c8alu_pkg::OP_CMP: cmp_reg = req.accumulator;
      c8alu_pkg::OP_CPX: cmp_reg = req.index_x;
      default:           cmp_reg = req.index_y;
    endcase
  end
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, req.operand};

  always_comb begin
    res.result   = 8'h00;
    res.carry    = req.carry_in;
    res.overflow = req.overflow_in;
    res.penalty  = 1'b0;
    case (req.op)
      c8alu_pkg::OP_ADC, c8alu_pkg::OP_SBC: begin
        if (use_dec) begin
          res.result  = dec_sum[7:0];
          res.carry   = dec_sum[8];
          res.penalty = 1'b1;
        end else begin
          res.result   = bin_sum[7:0];
          res.carry    = bin_sum[8];
          res.overflow = bin_v;
        end
      end
      c8alu_pkg::OP_AND: res.result = req.accumulator & req.operand;
      c8alu_pkg::OP_ASL: begin
        res.result = {req.operand[6:0], 1'b0};
        res.carry  = req.operand[7];
      end
      c8alu_pkg::OP_BIT: begin
        res.result   = req.accumulator;
        res.overflow = req.operand[6];
      end
      c8alu_pkg::OP_CMP, c8alu_pkg::OP_CPX, c8alu_pkg::OP_CPY: begin
        res.result = cmp_reg;
        res.carry  = ~cmp_diff[8];
      end
      c8alu_pkg::OP_DEC: res.result = req.operand - 8'd1;
      c8alu_pkg::OP_EOR: res.result = req.accumulator ^ req.operand;
      c8alu_pkg::OP_INC: res.result = req.operand + 8'd1;
      c8alu_pkg::OP_LD:  res.result = req.operand;
      c8alu_pkg::OP_LSR: begin
        res.result = {1'b0, req.operand[7:1]};
        res.carry  = req.operand[0];
      end
      c8alu_pkg::OP_ORA: res.result = req.accumulator | req.operand;
      c8alu_pkg::OP_ROL: begin
        res.result = {req.operand[6:0], req.carry_in};
        res.carry  = req.operand[7];
      end
      c8alu_pkg::OP_ROR: begin
        res.result = {req.carry_in, req.operand[7:1]};
        res.carry  = req.operand[0];
      end
      default: res.result = req.operand;
    endcase

    // Z and N: BIT takes Z from A&M and N from M bit 7, compares look at the difference, the rest at the result
    case (req.op)
      c8alu_pkg::OP_BIT: begin
        res.zero     = ((req.accumulator & req.operand) == 8'h00);
        res.negative = req.operand[7];
      end
      c8alu_pkg::OP_CMP, c8alu_pkg::OP_CPX, c8alu_pkg::OP_CPY: begin
        res.zero     = (cmp_diff[7:0] == 8'h00);
        res.negative = cmp_diff[7];
      end
      default: begin
        res.zero     = (res.result == 8'h00);
        res.negative = res.result[7];
      end
    endcase
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for the 8-bit ALU with decimal mode: random traffic, flow control, decimal toggling.
module testbench;

  // Receiver stall patterns
  localparam int RX_FREE     = 0;
  localparam int RX_HALF     = 1;
  localparam int RX_SPARSE   = 2;
  localparam int RX_PERIODIC = 3;

  localparam int HOLD_CYCLES = 60;    // long receiver hold-off, fills the two stages
  localparam int IDLE_LIMIT  = 5000;  // cycles with no beat on either side before giving up
  localparam int DRAIN_WAIT  = 4;     // input reg + result reg, with a little margin

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  c8alu_pkg::req_t drv_req = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_result;
  logic out_carry_out;
  logic out_zero_out;
  logic out_negative_out;
  logic out_overflow_out;
  logic out_decimal_penalty;

  // Operations waiting to be offered, and results owed by the block
  c8alu_pkg::req_t ops_pending[$];
  c8alu_pkg::res_t alu_results_due[$];

  // Mirror of decimal_enable; reset value is 1
  logic dec_enable_mirror = 1'b1;

  int pushed_cnt = 0;
  int beats_in = 0;
  int beats_out = 0;
  int pending_cnt = 0;
  int mismatch_cnt = 0;
  int idle_cycles = 0;
  int bcd_beats = 0;
  int bcd_masked = 0;

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;

  // Shared between the stimulus thread and the two drivers
  bit quiet = 1'b0;
  bit hold_arm = 1'b0;
  bit hold_seen = 1'b0;

  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  int rx_mode = RX_FREE;
  int rx_left = 0;
  int rx_phase = 0;
  logic rx_rdy;

  always #5 clk = ~clk;

  cpu8_alu_with_decimal_mode_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (drv_req.op),
    .in_operand          (drv_req.operand),
    .in_accumulator      (drv_req.accumulator),
    .in_index_x          (drv_req.index_x),
    .in_index_y          (drv_req.index_y),
    .in_carry_in         (drv_req.carry_in),
    .in_overflow_in      (drv_req.overflow_in),
    .in_decimal_in       (drv_req.decimal_in),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result          (out_result),
    .out_carry_out       (out_carry_out),
    .out_zero_out        (out_zero_out),
    .out_negative_out    (out_negative_out),
    .out_overflow_out    (out_overflow_out),
    .out_decimal_penalty (out_decimal_penalty)
  );

  // Expected ALU outcome for one operation under the given decimal_enable.
  function automatic c8alu_pkg::res_t alu_compute(c8alu_pkg::req_t rq, logic dec_on);
    c8alu_pkg::res_t rs;
    logic [7:0] m;
    logic [7:0] src;
    logic [5:0] lo;
    logic       lc;
    logic [9:0] sum;
    logic [8:0] diff;
    rs = '0;
    rs.carry = rq.carry_in;
    rs.overflow = rq.overflow_in;
    m = rq.operand;
    case (rq.op)
      c8alu_pkg::OP_ADC, c8alu_pkg::OP_SBC: begin
        // SBC is ADC of the ones' complement
        if (rq.op == c8alu_pkg::OP_SBC) m = ~m;
        if (!dec_on || !rq.decimal_in) begin
          sum = {2'b00, rq.accumulator} + {2'b00, m} + {9'd0, rq.carry_in};
          rs.overflow = ~(rq.accumulator[7] ^ m[7]) & (rq.accumulator[7] ^ sum[7]);
        end else begin
          // BCD path: nibble fix-ups, no digit validation, V untouched
          rs.penalty = 1'b1;
          lo = {2'b00, rq.accumulator[3:0]} + {2'b00, m[3:0]} + {5'd0, rq.carry_in};
          if (rq.op == c8alu_pkg::OP_ADC) begin
            if (lo > 6'd9) lo = lo + 6'd6;
            lc = lo > 6'd15;
          end else begin
            lc = lo > 6'd15;
            if (!lc) lo = lo - 6'd6;
          end
          sum = {2'b00, rq.accumulator[7:4], 4'h0} + {2'b00, m[7:4], 4'h0}
              + {5'd0, lc, 4'h0} + {6'd0, lo[3:0]};
          if (rq.op == c8alu_pkg::OP_ADC) begin
            if (sum > 10'h09f) sum = sum + 10'h060;
          end else if (sum <= 10'h0ff) begin
            sum = sum - 10'h060;
          end
        end
        rs.carry = sum[8];
        rs.result = sum[7:0];
      end
      c8alu_pkg::OP_AND: rs.result = rq.accumulator & m;
      c8alu_pkg::OP_ASL: begin
        rs.carry = m[7];
        rs.result = {m[6:0], 1'b0};
      end
      c8alu_pkg::OP_BIT: begin
        rs.result = rq.accumulator;
        rs.zero = (rq.accumulator & m) == 8'h00;
        rs.overflow = m[6];
        rs.negative = m[7];
      end
      c8alu_pkg::OP_CMP, c8alu_pkg::OP_CPX, c8alu_pkg::OP_CPY: begin
        src = (rq.op == c8alu_pkg::OP_CMP) ? rq.accumulator :
              (rq.op == c8alu_pkg::OP_CPX) ? rq.index_x : rq.index_y;
        diff = {1'b0, src} - {1'b0, m};
        rs.carry = ~diff[8];
        rs.zero = diff[7:0] == 8'h00;
        rs.negative = diff[7];
        rs.result = src;
      end
      c8alu_pkg::OP_DEC: rs.result = m - 8'd1;
      c8alu_pkg::OP_EOR: rs.result = rq.accumulator ^ m;
      c8alu_pkg::OP_INC: rs.result = m + 8'd1;
      c8alu_pkg::OP_LD:  rs.result = m;
      c8alu_pkg::OP_LSR: begin
        rs.carry = m[0];
        rs.result = {1'b0, m[7:1]};
      end
      c8alu_pkg::OP_ORA: rs.result = rq.accumulator | m;
      c8alu_pkg::OP_ROL: begin
        rs.carry = m[7];
        rs.result = {m[6:0], rq.carry_in};
      end
      default: begin  // ROR
        rs.carry = m[0];
        rs.result = {rq.carry_in, m[7:1]};
      end
    endcase
    // BIT and the compares set Z/N above; everything else from the result byte
    if (rq.op != c8alu_pkg::OP_BIT && rq.op != c8alu_pkg::OP_CMP &&
        rq.op != c8alu_pkg::OP_CPX && rq.op != c8alu_pkg::OP_CPY) begin
      rs.zero = rs.result == 8'h00;
      rs.negative = rs.result[7];
    end
    return rs;
  endfunction

  function automatic c8alu_pkg::req_t mk_op(c8alu_pkg::op_t op, logic [7:0] m,
                                            logic [7:0] a, logic [7:0] x,
                                            logic [7:0] y, logic c, logic v, logic d);
    c8alu_pkg::req_t rq;
    rq.op = op;
    rq.operand = m;
    rq.accumulator = a;
    rq.index_x = x;
    rq.index_y = y;
    rq.carry_in = c;
    rq.overflow_in = v;
    rq.decimal_in = d;
    return rq;
  endfunction

  // Byte biased towards boundary values and valid BCD
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 6))
          0: b = 8'h00;
          1: b = 8'hff;
          2: b = 8'h7f;
          3: b = 8'h80;
          4: b = 8'h99;
          5: b = 8'h0f;
          default: b = 8'h01;
        endcase
      end
      1: begin
        b[7:4] = 4'($urandom_range(0, 9));
        b[3:0] = 4'($urandom_range(0, 9));
      end
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic c8alu_pkg::req_t rand_op();
    c8alu_pkg::req_t rq;
    // ADC/SBC get extra weight, they carry the decimal path
    if ($urandom_range(0, 2) == 0) begin
      rq.op = ($urandom_range(0, 1) != 0) ? c8alu_pkg::OP_SBC : c8alu_pkg::OP_ADC;
    end else begin
      rq.op = c8alu_pkg::op_t'($urandom_range(0, 15));
    end
    rq.operand = pick_byte();
    rq.accumulator = pick_byte();
    rq.index_x = pick_byte();
    rq.index_y = pick_byte();
    rq.carry_in = 1'($urandom_range(0, 1));
    rq.overflow_in = 1'($urandom_range(0, 1));
    rq.decimal_in = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Sender: bursts of random length, random gaps; no gaps when quiet.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0 && !quiet) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (ops_pending.size() > 0) begin
        drv_req <= ops_pending.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 16);
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: own stall pattern, switched at random; long hold when armed.
  always @(negedge clk) begin
    if (hold_arm != hold_seen) begin
      hold_seen = hold_arm;
      hold_left = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_FREE, RX_PERIODIC);
      rx_left = $urandom_range(8, 64);
    end else begin
      rx_left--;
    end
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      rx_rdy = 1'b0;
    end else if (quiet) begin
      rx_rdy = 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:   rx_rdy = 1'b1;
        RX_HALF:   rx_rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rx_rdy = $urandom_range(0, 3) == 0;
        default:   rx_rdy = (rx_phase % 5) < 2;
      endcase
    end
    out_ready <= rx_rdy;
  end

  // Monitor: predict on input beats, check output beats, mirror config writes.
  always @(posedge clk) begin
    c8alu_pkg::res_t due;
    in_fire = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    if (in_fire) begin
      due = alu_compute(drv_req, dec_enable_mirror);
      alu_results_due.push_back(due);
      pending_cnt++;
      beats_in++;
      if (due.penalty) bcd_beats++;
      if ((drv_req.op == c8alu_pkg::OP_ADC || drv_req.op == c8alu_pkg::OP_SBC) &&
          drv_req.decimal_in && !dec_enable_mirror) bcd_masked++;
    end
    if (out_fire) begin
      beats_out++;
      if (pending_cnt == 0) begin
        $display("%0t: unexpected result beat, expected none actual result %h",
                 $time, out_result);
        mismatch_cnt++;
      end else begin
        due = alu_results_due.pop_front();
        pending_cnt--;
        compare_field("result", due.result, out_result);
        compare_field("carry", {7'd0, due.carry}, {7'd0, out_carry_out});
        compare_field("zero", {7'd0, due.zero}, {7'd0, out_zero_out});
        compare_field("negative", {7'd0, due.negative}, {7'd0, out_negative_out});
        compare_field("overflow", {7'd0, due.overflow}, {7'd0, out_overflow_out});
        compare_field("penalty", {7'd0, due.penalty}, {7'd0, out_decimal_penalty});
      end
    end
    if (rst_n && cfg_wr_en) dec_enable_mirror = cfg_wr_data;
    // watchdog
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Waits until every queued operation has gone in and every result is back.
  task automatic drain();
    wait (beats_in == pushed_cnt && pending_cnt == 0);
    @(posedge clk);
  endtask

  task automatic write_dec_enable(logic val);
    drain();
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // One block of random traffic, then a full drain (sender pauses).
  task automatic run_chunk(int n, bit calm, bit long_hold);
    quiet = calm;
    if (long_hold) hold_arm = ~hold_arm;
    repeat (n) begin
      ops_pending.push_back(rand_op());
      pushed_cnt++;
    end
    drain();
    quiet = 1'b0;
  endtask

  task automatic push_op(c8alu_pkg::req_t rq);
    ops_pending.push_back(rq);
    pushed_cnt++;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: decimal support on (reset value)
    push_op(mk_op(c8alu_pkg::OP_ADC, 8'h01, 8'h7f, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));  // signed ovf
    push_op(mk_op(c8alu_pkg::OP_ADC, 8'h01, 8'hff, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));  // carry out
    push_op(mk_op(c8alu_pkg::OP_SBC, 8'h01, 8'h80, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));  // borrow ovf
    push_op(mk_op(c8alu_pkg::OP_ADC, 8'h01, 8'h99, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));  // 99+1 wraps
    push_op(mk_op(c8alu_pkg::OP_ADC, 8'h46, 8'h58, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));  // carry in
    push_op(mk_op(c8alu_pkg::OP_ADC, 8'hff, 8'hff, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1));  // bad digits
    push_op(mk_op(c8alu_pkg::OP_SBC, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1));  // BCD borrow
    push_op(mk_op(c8alu_pkg::OP_SBC, 8'h12, 8'h46, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
    push_op(mk_op(c8alu_pkg::OP_SBC, 8'hfa, 8'haf, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));  // bad digits
    push_op(mk_op(c8alu_pkg::OP_AND, 8'h00, 8'hff, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    push_op(mk_op(c8alu_pkg::OP_ASL, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
    push_op(mk_op(c8alu_pkg::OP_BIT, 8'hc0, 8'h3f, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    push_op(mk_op(c8alu_pkg::OP_CMP, 8'h10, 8'h10, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));  // equal
    push_op(mk_op(c8alu_pkg::OP_CPX, 8'hff, 8'h00, 8'h00, 8'hff, 1'b1, 1'b0, 1'b0));  // X below
    push_op(mk_op(c8alu_pkg::OP_CPY, 8'h00, 8'h00, 8'hff, 8'hff, 1'b0, 1'b1, 1'b0));
    push_op(mk_op(c8alu_pkg::OP_DEC, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    push_op(mk_op(c8alu_pkg::OP_EOR, 8'hff, 8'hff, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
    push_op(mk_op(c8alu_pkg::OP_INC, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    push_op(mk_op(c8alu_pkg::OP_LD,  8'h80, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    push_op(mk_op(c8alu_pkg::OP_LSR, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    push_op(mk_op(c8alu_pkg::OP_ORA, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
    push_op(mk_op(c8alu_pkg::OP_ROL, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    push_op(mk_op(c8alu_pkg::OP_ROR, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    // D set, not ADC/SBC
    push_op(mk_op(c8alu_pkg::OP_AND, 8'hff, 8'hff, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
    drain();

    // Random, decimal support on
    run_chunk(100, 1'b0, 1'b0);
    run_chunk(100, 1'b1, 1'b1);  // receiver holds off while the sender keeps going
    run_chunk(100, 1'b0, 1'b0);
    run_chunk(100, 1'b0, 1'b0);

    // Binary forced
    write_dec_enable(1'b0);
    run_chunk(100, 1'b0, 1'b0);
    run_chunk(100, 1'b1, 1'b0);
    run_chunk(100, 1'b0, 1'b1);

    // Decimal support back on
    write_dec_enable(1'b1);
    run_chunk(110, 1'b0, 1'b0);
    run_chunk(115, 1'b0, 1'b0);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Ran %0d ALU beats (%0d returned) across all 16 operations, decimal enable 1/0/1",
             beats_in, beats_out);
    $display("BCD-adjusted ADC/SBC: %0d, decimal flag ignored while disabled: %0d",
             bcd_beats, bcd_masked);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
